@@ rtl/ctld_pkg.sv @@
// ctld_pkg: shared constants, types and helpers for cursor_to_look_direction
// used by ctld_cordic, ctld_mul and the top level; no dependencies
package ctld_pkg;

	localparam int CORDIC_STEPS  = 16;
	localparam int OUT_FRAC_BITS = 14;

	localparam int ATAN_DEPTH = 30;
	localparam int ATAN_W     = $clog2(ATAN_DEPTH);

	localparam int ANG_W   = 32;
	localparam int VAL_W   = 32;
	localparam int DIFF_W  = 33;
	localparam int TPU_W   = 28;
	localparam int PROD_W  = DIFF_W + VAL_W;
	localparam int DIR_W   = 16;

	localparam logic signed [VAL_W-1:0] CORDIC_GAIN = 32'sh26DD3B6A;
	localparam logic [ANG_W-1:0]        EIGHTH_TURN = 32'h2000_0000;

	localparam int SH_PROD = 60 - OUT_FRAC_BITS;
	localparam int SH_SIN  = 30 - OUT_FRAC_BITS;

	localparam logic signed [PROD_W-1:0] RND_PROD =
		(SH_PROD > 0) ? (PROD_W'(1) <<< (SH_PROD - 1)) : '0;
	localparam logic signed [PROD_W-1:0] RND_SIN =
		(SH_SIN > 0) ? (PROD_W'(1) <<< (SH_SIN - 1)) : '0;
	localparam logic signed [PROD_W-1:0] OUT_LIM = PROD_W'(1) <<< OUT_FRAC_BITS;

	localparam logic [ANG_W-1:0] ATAN_TAB [ATAN_DEPTH] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
	};

	typedef struct packed {
		logic                    done;
		logic signed [VAL_W-1:0] cos_v;
		logic signed [VAL_W-1:0] sin_v;
	} sc_res_t;

	function automatic logic [DIR_W-1:0] sat_out(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] r;
		begin
			r = v;
			if (v > OUT_LIM) begin
				r = OUT_LIM;
			end else if (v < -OUT_LIM) begin
				r = -OUT_LIM;
			end
			return r[DIR_W-1:0];
		end
	endfunction

endpackage

@@ rtl/ctld_mul.sv @@
// ctld_mul: shared signed multiplier with registered product
// depends on ctld_pkg
module ctld_mul import ctld_pkg::*; (
	input  logic                     clk,
	input  logic signed [DIFF_W-1:0] a,
	input  logic signed [VAL_W-1:0]  b,
	output logic signed [PROD_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

@@ rtl/ctld_cordic.sv @@
// ctld_cordic: iterative rotation cordic, one step per cycle, quadrant fold
// depends on ctld_pkg
module ctld_cordic import ctld_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ANG_W-1:0] angle,
	output sc_res_t          res
);

	localparam logic [ATAN_W-1:0] LAST_STEP = ATAN_W'(CORDIC_STEPS - 1);

	logic                    busy_q;
	logic                    done_q;
	logic [ATAN_W-1:0]       i_q;
	logic [1:0]              quad_q;
	logic signed [VAL_W-1:0] x_q, y_q, z_q;
	logic signed [VAL_W-1:0] cos_q, sin_q;

	logic [ANG_W-1:0]        shifted;
	logic [1:0]              quad;
	logic signed [VAL_W-1:0] xs, ys, x_n, y_n, z_n, at;

	always_comb begin
		shifted = angle + EIGHTH_TURN;
		quad    = shifted[ANG_W-1 -: 2];
		xs      = x_q >>> i_q;
		ys      = y_q >>> i_q;
		at      = ATAN_TAB[i_q];
		if (!z_q[VAL_W-1]) begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - at;
		end else begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
			quad_q <= '0;
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
			cos_q  <= '0;
			sin_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				quad_q <= quad;
				x_q    <= CORDIC_GAIN;
				y_q    <= '0;
				z_q    <= angle - {quad, {(ANG_W-2){1'b0}}};
			end else if (busy_q) begin
				x_q <= x_n;
				y_q <= y_n;
				z_q <= z_n;
				i_q <= i_q + 1'b1;
				if (i_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					case (quad_q)
						2'd0: begin
							cos_q <= x_n;
							sin_q <= y_n;
						end
						2'd1: begin
							cos_q <= -y_n;
							sin_q <= x_n;
						end
						2'd2: begin
							cos_q <= -x_n;
							sin_q <= -y_n;
						end
						default: begin
							cos_q <= y_n;
							sin_q <= -x_n;
						end
					endcase
				end
			end
		end
	end

	assign res.done  = done_q;
	assign res.cos_v = cos_q;
	assign res.sin_v = sin_q;

endmodule

@@ rtl/cursor_to_look_direction.sv @@
// cursor_to_look_direction: cursor samples to yaw/pitch and a unit look vector
// depends on ctld_pkg, ctld_mul, ctld_cordic
//
// channel  dir  handshake            payload
// in       in   in_valid / in_stall   cursor_x, cursor_y
// out      out  out_valid / out_stall dir_x, dir_y, dir_z, yaw_out, pitch_out
// cfg      in   cfg_valid / cfg_ready cfg_data (turn_per_unit)
//
// an item runs from input transfer through MUL_X, MUL_Y, ADD_P, YSTART, CORD_Y, CORD_P,
// MUL_C, MUL_S, FIN and OUT to the output registers; the first sample after reset skips
// both increments and goes straight to YSTART; the next sample is taken only back in IDLE
// the single cordic unit is run for yaw, then pitch
// the multiplier is shared by both angle increments and both cos(pitch) products
// input is stalled while an item is in work; a waiting result is held in the output register
// reset clears angles and previous position, sets the first-sample flag and turn_per_unit to default
module cursor_to_look_direction import ctld_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [31:0]      cursor_x,
	input  logic signed [31:0]      cursor_y,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [DIR_W-1:0] dir_x,
	output logic signed [DIR_W-1:0] dir_y,
	output logic signed [DIR_W-1:0] dir_z,
	output logic [ANG_W-1:0]        yaw_out,
	output logic [ANG_W-1:0]        pitch_out,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [TPU_W-1:0]        cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_ADD_P,
		ST_YSTART,
		ST_CORD_Y,
		ST_CORD_P,
		ST_MUL_C,
		ST_MUL_S,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t                   state_q;
	logic                     first_q;
	logic [TPU_W-1:0]         tpu_q;
	logic [ANG_W-1:0]         prev_x_q, prev_y_q, yaw_q, pitch_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic signed [VAL_W-1:0]  cy_q, sy_q, cp_q, sp_q;
	logic [DIR_W-1:0]         dirx_q, dirz_q;

	logic signed [DIFF_W-1:0] mul_a;
	logic signed [VAL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic [39:0]              inc_rnd;
	logic signed [PROD_W-1:0] prod_shr, sin_shr;
	logic                     cs_start;
	logic [ANG_W-1:0]         cs_angle;
	sc_res_t                  cs_res;
	logic                     in_xfer;

	ctld_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	ctld_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cs_start),
		.angle  (cs_angle),
		.res    (cs_res)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && !in_stall;

	always_comb begin
		mul_a = dx_q;
		mul_b = VAL_W'({4'b0, tpu_q});
		case (state_q)
			ST_MUL_Y: mul_a = dy_q;
			ST_MUL_C: begin
				mul_a = DIFF_W'(cy_q);
				mul_b = cp_q;
			end
			ST_MUL_S: begin
				mul_a = DIFF_W'(sy_q);
				mul_b = cp_q;
			end
			default: mul_a = dx_q;
		endcase
	end

	// angle increment: product rounded at bit 8, kept modulo one turn
	assign inc_rnd  = mul_p[39:0] + 40'd128;
	assign prod_shr = (mul_p + RND_PROD) >>> SH_PROD;
	assign sin_shr  = (PROD_W'(sp_q) + RND_SIN) >>> SH_SIN;

	assign cs_start = (state_q == ST_YSTART) || (state_q == ST_CORD_Y && cs_res.done);
	assign cs_angle = (state_q == ST_YSTART) ? yaw_q : pitch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			first_q   <= 1'b1;
			tpu_q     <= TPU_W'(1193046);
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			yaw_q     <= '0;
			pitch_q   <= '0;
			dx_q      <= '0;
			dy_q      <= '0;
			cy_q      <= '0;
			sy_q      <= '0;
			cp_q      <= '0;
			sp_q      <= '0;
			dirx_q    <= '0;
			dirz_q    <= '0;
			out_valid <= 1'b0;
			dir_x     <= '0;
			dir_y     <= '0;
			dir_z     <= '0;
			yaw_out   <= '0;
			pitch_out <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tpu_q <= cfg_data;
			end
			if (out_valid && !out_stall && state_q != ST_OUT) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						dx_q     <= DIFF_W'(cursor_x) - DIFF_W'(signed'(prev_x_q));
						dy_q     <= DIFF_W'(signed'(prev_y_q)) - DIFF_W'(cursor_y);
						prev_x_q <= cursor_x;
						prev_y_q <= cursor_y;
						first_q  <= 1'b0;
						state_q  <= first_q ? ST_YSTART : ST_MUL_X;
					end
				end
				ST_MUL_X: state_q <= ST_MUL_Y;
				ST_MUL_Y: begin
					yaw_q   <= yaw_q + inc_rnd[39:8];
					state_q <= ST_ADD_P;
				end
				ST_ADD_P: begin
					pitch_q <= pitch_q + inc_rnd[39:8];
					state_q <= ST_YSTART;
				end
				ST_YSTART: state_q <= ST_CORD_Y;
				ST_CORD_Y: begin
					if (cs_res.done) begin
						cy_q    <= cs_res.cos_v;
						sy_q    <= cs_res.sin_v;
						state_q <= ST_CORD_P;
					end
				end
				ST_CORD_P: begin
					if (cs_res.done) begin
						cp_q    <= cs_res.cos_v;
						sp_q    <= cs_res.sin_v;
						state_q <= ST_MUL_C;
					end
				end
				ST_MUL_C: state_q <= ST_MUL_S;
				ST_MUL_S: begin
					dirx_q  <= sat_out(prod_shr);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					dirz_q  <= sat_out(prod_shr);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						dir_x     <= dirx_q;
						dir_y     <= sat_out(sin_shr);
						dir_z     <= dirz_q;
						yaw_out   <= yaw_q;
						pitch_out <= pitch_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result presented outside output step");

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		cs_res.done |-> (state_q == ST_CORD_Y || state_q == ST_CORD_P))
		else $error("cordic finished while sequencer not waiting");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_MUL_X || state_q == ST_YSTART))
		else $error("input transfer did not start work");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(dir_x) && $stable(yaw_out))
		else $error("waiting result overwritten");
`endif

endmodule
